// ===== rtl/ile_pkg.sv =====
// Package for the indexed list engine: commands, status codes, cell actions,
// the sequencer state type and the cell control bundle. Depends on nothing.
package ile_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int CMD_W        = 3;
    localparam int POS_W        = 7;
    localparam int STATUS_W     = 2;
    localparam int FOUND_W      = 6;
    localparam int COUNT_OUT_W  = 7;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 112;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_INSERT    = 3'd1,
        CMD_OVERWRITE = 3'd2,
        CMD_REMOVE    = 3'd3,
        CMD_CLEAR     = 3'd4,
        CMD_READ      = 3'd5,
        CMD_SEARCH    = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_SHIFT_IN,
        ACT_SHIFT_OUT,
        ACT_SEARCH
    } act_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIND,
        S_HOLD
    } state_t;

    typedef struct packed {
        act_t               act;
        logic [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

// ===== rtl/ile_cell.sv =====
// One list slot: holds a value and a match flag, takes its neighbor's value
// on a shift. Depends on ile_pkg.
module ile_cell #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ile_pkg::cell_ctl_t          ctl,
    input  logic [$clog2(CAPACITY)-1:0] index,
    input  logic [$clog2(CAPACITY+1)-1:0] count,
    input  logic [ile_pkg::VALUE_W-1:0] left_value,
    input  logic [ile_pkg::VALUE_W-1:0] right_value,
    output logic [ile_pkg::VALUE_W-1:0] value,
    output logic                        match
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic [ile_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                        match_reg, match_next;

    always_comb
    begin
        value_next = value_reg;
        match_next = match_reg;
        case (ctl.act)
            ile_pkg::ACT_WRITE:
            begin
                if (index == MY_IDX)
                begin
                    value_next = ctl.value;
                end
            end
            ile_pkg::ACT_SHIFT_IN:
            begin
                if (index == MY_IDX)
                begin
                    value_next = ctl.value;
                end
                else if (MY_IDX > index)
                begin
                    value_next = left_value;
                end
            end
            ile_pkg::ACT_SHIFT_OUT:
            begin
                if (MY_IDX >= index)
                begin
                    value_next = right_value;
                end
            end
            ile_pkg::ACT_SEARCH:
            begin
                match_next = (value_reg == ctl.value) && (MY_CNT < count);
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

// ===== rtl/ile_find.sv =====
// Find-first over the row of match flags: isolate the lowest set flag and
// encode its slot number. Depends on ile_pkg for parameter defaults only.
module ile_find #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic [CAPACITY-1:0]         match_vec,
    output logic                        any,
    output logic [$clog2(CAPACITY)-1:0] first_idx
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic [CAPACITY-1:0] first_hot;

    // lowest set bit: x & -x
    assign first_hot = match_vec & (~match_vec + CAPACITY'(1));
    assign any       = |match_vec;

    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_hot[i])
            begin
                first_idx = first_idx | IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/indexed_list_engine.sv =====
// Top level of the indexed list engine: command sequencer, row of list
// cells, find-first unit and output register. Depends on ile_pkg, ile_cell
// and ile_find.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   s_axis   | in  | s_tvalid/s_tready  | command, position, item_value
//   m_axis   | out | m_tvalid/m_tready  | status, result_value, found_position,
//            |     |                    | entry_count, first_value, last_value,
//            |     |                    | is_empty
//
// One command is in flight at a time. A command steps from accept through
// execute in the cell row to loading the output register; search adds a
// find step before the load, which runs the find-first over the match flags
// the cells registered. The cells shift the whole row at once, in the
// execute step, for insert and remove. Reset clears the count and the
// sequencer; cell contents are undefined until written. A new command is
// taken while the previous result waits on m_tready; its result holds in
// the sequencer until the output register frees up.
module indexed_list_engine #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] command, [9:3] position, [41:10] item_value, [47:42] zero
    input  logic [ile_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [33:2] result_value, [39:34] found_position,
    // [46:40] entry_count, [78:47] first_value, [110:79] last_value,
    // [111] is_empty
    output logic [ile_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
    localparam int VW    = ile_pkg::VALUE_W;

    ile_pkg::state_t state_reg, state_next;

    ile_pkg::cmd_t                cmd_reg;
    logic [ile_pkg::POS_W-1:0]    pos_reg;
    logic [VW-1:0]                val_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    ile_pkg::status_t             status_reg, status_next;
    logic [VW-1:0]                result_reg, result_next;
    logic [ile_pkg::FOUND_W-1:0]  found_reg;
    logic                         out_valid_reg;
    logic [ile_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                 accept;
    logic                 out_free;
    logic                 load_out;
    logic                 exec_en;
    logic                 find_en;

    ile_pkg::cell_ctl_t   ctl;
    logic [IDX_W-1:0]     cell_index;
    logic [VW-1:0]        cell_value [CAPACITY];
    logic [CAPACITY-1:0]  match_vec;
    logic                 find_any;
    logic [IDX_W-1:0]     find_idx;

    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic                 full;
    logic [IDX_W-1:0]     pos_idx;
    logic [IDX_W-1:0]     last_idx;
    logic [VW-1:0]        first_val;
    logic [VW-1:0]        last_val;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ile_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ile_pkg::S_EXEC;
                end
            end
            ile_pkg::S_EXEC:
            begin
                if (cmd_reg == ile_pkg::CMD_SEARCH)
                begin
                    state_next = ile_pkg::S_FIND;
                end
                else
                begin
                    state_next = ile_pkg::S_HOLD;
                end
            end
            ile_pkg::S_FIND:
            begin
                state_next = ile_pkg::S_HOLD;
            end
            ile_pkg::S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ile_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ile_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        s_tready = 1'b0;
        exec_en  = 1'b0;
        find_en  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ile_pkg::S_IDLE: s_tready = 1'b1;
            ile_pkg::S_EXEC: exec_en  = 1'b1;
            ile_pkg::S_FIND: find_en  = 1'b1;
            ile_pkg::S_HOLD: load_out = out_free;
            default:         s_tready = 1'b0;
        endcase
    end

    // ---------------- command decode for the execute cycle ----------------
    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign pos_idx  = pos_ext[IDX_W-1:0];
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        ctl.act     = ile_pkg::ACT_NONE;
        ctl.value   = val_reg;
        cell_index  = pos_idx;
        count_next  = count_reg;
        status_next = ile_pkg::ST_OK;
        result_next = '0;
        if (exec_en)
        begin
            case (cmd_reg)
                ile_pkg::CMD_APPEND:
                begin
                    if (full)
                    begin
                        status_next = ile_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.act    = ile_pkg::ACT_WRITE;
                        cell_index = IDX_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ile_pkg::CMD_INSERT:
                begin
                    if (pos_ext > cnt_ext)
                    begin
                        status_next = ile_pkg::ST_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = ile_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.act    = ile_pkg::ACT_SHIFT_IN;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ile_pkg::CMD_OVERWRITE:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        status_next = ile_pkg::ST_RANGE;
                    end
                    else
                    begin
                        ctl.act = ile_pkg::ACT_WRITE;
                    end
                end
                ile_pkg::CMD_REMOVE:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        status_next = ile_pkg::ST_RANGE;
                    end
                    else
                    begin
                        result_next = cell_value[pos_idx];
                        ctl.act     = ile_pkg::ACT_SHIFT_OUT;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                ile_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                ile_pkg::CMD_READ:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        status_next = ile_pkg::ST_RANGE;
                    end
                    else
                    begin
                        result_next = cell_value[pos_idx];
                    end
                end
                ile_pkg::CMD_SEARCH:
                begin
                    ctl.act = ile_pkg::ACT_SEARCH;
                end
                default:
                begin
                    // unused command code: change nothing, report ok
                    status_next = ile_pkg::ST_OK;
                end
            endcase
        end
    end

    // ---------------- row of cells ----------------
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [VW-1:0] left_v;
        logic [VW-1:0] right_v;

        if (g == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = cell_value[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_mid_r
            assign right_v = cell_value[g+1];
        end

        ile_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .index       (cell_index),
            .count       (count_reg),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[g]),
            .match       (match_vec[g])
        );
    end

    ile_find #(
        .CAPACITY (CAPACITY)
    ) u_find (
        .match_vec (match_vec),
        .any       (find_any),
        .first_idx (find_idx)
    );

    // ---------------- output beat assembly ----------------
    assign first_val = (count_reg != '0) ? cell_value[0] : '0;
    assign last_val  = (count_reg != '0) ? cell_value[last_idx] : '0;

    always_comb
    begin
        out_data_next = {
            (count_reg == '0),
            last_val,
            first_val,
            ile_pkg::COUNT_OUT_W'(count_reg),
            found_reg,
            result_reg,
            status_reg
        };
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ile_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: capture the command, then the per-command result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= ile_pkg::cmd_t'(s_tdata[ile_pkg::CMD_W-1:0]);
            pos_reg <= s_tdata[ile_pkg::CMD_W +: ile_pkg::POS_W];
            val_reg <= s_tdata[ile_pkg::CMD_W + ile_pkg::POS_W +: VW];
        end
        if (exec_en)
        begin
            status_reg <= status_next;
            result_reg <= result_next;
            found_reg  <= '0;
        end
        if (find_en)
        begin
            // miss keeps the found position at zero
            status_reg <= find_any ? ile_pkg::ST_OK : ile_pkg::ST_MISS;
            found_reg  <= find_any ? ile_pkg::FOUND_W'(find_idx) : '0;
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
